// ===== rtl/core/cmac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cmac_pkg;

  localparam int unsigned BlkW    = 128;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned NumRk   = 11;
  localparam int unsigned RndW    = 4;
  localparam int unsigned FillW   = 5;
  localparam int unsigned BlkBytes = 16;
  localparam logic [RndW-1:0] LastRnd = 4'd10;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [7:0] GfPoly = 8'h87;

  // byte x sits at bits 8*(255-x) +: 8
  localparam logic [2047:0] SboxTbl = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  typedef struct packed {
    logic             start;
    logic [BlkW-1:0]  data;
  } cmac_job_t;

  typedef struct packed {
    logic keys_ok;   // round keys and subkeys valid
    logic idle;      // a new job may start
    logic done;      // result valid this cycle
  } cmac_stat_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    sbox = SboxTbl[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [RndW-1:0] i);
    logic [7:0] r;
    unique case (i)
      4'd0: r = 8'h01;
      4'd1: r = 8'h02;
      4'd2: r = 8'h04;
      4'd3: r = 8'h08;
      4'd4: r = 8'h10;
      4'd5: r = 8'h20;
      4'd6: r = 8'h40;
      4'd7: r = 8'h80;
      4'd8: r = 8'h1b;
      4'd9: r = 8'h36;
      default: r = 8'h00;
    endcase
    rcon = r;
  endfunction

  // SubBytes, ShiftRows and (unless final) MixColumns; byte 0 in the MSBs
  function automatic logic [BlkW-1:0] aes_round(input logic [BlkW-1:0] s, input logic fin);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [BlkW-1:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = sbox(s[127 - 8*(i + 4*((c + i) % 4)) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c + 1];
      a2 = t[4*c + 2];
      a3 = t[4*c + 3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (fin) begin
        r[127 - 32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127 - 32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                               a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
      end
    end
    aes_round = r;
  endfunction

  function automatic logic [BlkW-1:0] key_next(input logic [BlkW-1:0] k,
                                               input logic [RndW-1:0] i);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {sbox(k[23:16]) ^ rcon(i), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    key_next = {w0, w1, w2, w3};
  endfunction

  function automatic logic [BlkW-1:0] gf_double(input logic [BlkW-1:0] x);
    gf_double = {x[126:0], 1'b0} ^ {120'd0, (x[127] ? GfPoly : 8'h00)};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cmac_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmac_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [cmac_pkg::BlkW-1:0]      key_i,
  input  wire logic                           key_load_i,
  input  wire cmac_pkg::cmac_job_t            job_i,
  output cmac_pkg::cmac_stat_t                stat_o,
  output logic [cmac_pkg::BlkW-1:0]           result_o,
  output logic [cmac_pkg::BlkW-1:0]           k1_o,
  output logic [cmac_pkg::BlkW-1:0]           k2_o
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_KEXP,
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                       state_q;
  logic [cmac_pkg::RndW-1:0]    cnt_q;
  logic                         sub_q;
  logic                         done_q;
  logic [cmac_pkg::BlkW-1:0]    rk_q;
  logic [cmac_pkg::BlkW-1:0]    s_q;
  logic [cmac_pkg::BlkW-1:0]    k1_q;
  logic [cmac_pkg::BlkW-1:0]    k2_q;
  logic [cmac_pkg::BlkW-1:0]    rk_mem [cmac_pkg::NumRk];
  logic [cmac_pkg::BlkW-1:0]    rk_rd_q;
  logic [cmac_pkg::RndW-1:0]    rd_addr;
  logic                         rk_we;
  logic [cmac_pkg::BlkW-1:0]    rnd_out;
  logic                         kexp_end;

  assign kexp_end = (state_q == ST_KEXP) && (cnt_q == cmac_pkg::LastRnd);
  assign rk_we    = (state_q == ST_KEXP);
  assign rnd_out  = cmac_pkg::aes_round(s_q, cnt_q == cmac_pkg::LastRnd) ^ rk_rd_q;

  // read address runs one round ahead; rests on round key 0
  always_comb begin
    rd_addr = '0;
    if (state_q == ST_RUN) begin
      rd_addr = (cnt_q == cmac_pkg::LastRnd) ? '0 : cnt_q + 4'd1;
    end else if (kexp_end || (state_q == ST_IDLE && job_i.start)) begin
      rd_addr = 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rk_we) begin
      rk_mem[cnt_q] <= rk_q;
    end
    rk_rd_q <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      sub_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (key_load_i) begin
        state_q <= ST_LOAD;
      end else begin
        unique case (state_q)
          ST_LOAD: begin
            state_q <= ST_KEXP;
            cnt_q   <= '0;
          end
          ST_KEXP: begin
            if (kexp_end) begin
              // encrypt the zero block to get L
              state_q <= ST_RUN;
              cnt_q   <= 4'd1;
              sub_q   <= 1'b1;
            end else begin
              cnt_q <= cnt_q + 4'd1;
            end
          end
          ST_IDLE: begin
            if (job_i.start) begin
              state_q <= ST_RUN;
              cnt_q   <= 4'd1;
              sub_q   <= 1'b0;
            end
          end
          ST_RUN: begin
            if (cnt_q == cmac_pkg::LastRnd) begin
              state_q <= ST_IDLE;
              done_q  <= !sub_q;
            end else begin
              cnt_q <= cnt_q + 4'd1;
            end
          end
          default: state_q <= ST_LOAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      rk_q <= key_i;
    end else if (state_q == ST_KEXP) begin
      rk_q <= cmac_pkg::key_next(rk_q, cnt_q);
    end
    if (kexp_end) begin
      s_q <= rk_rd_q;
    end else if (state_q == ST_IDLE && job_i.start) begin
      s_q <= job_i.data ^ rk_rd_q;
    end else if (state_q == ST_RUN) begin
      s_q <= rnd_out;
    end
    if (state_q == ST_RUN && cnt_q == cmac_pkg::LastRnd && sub_q) begin
      k1_q <= cmac_pkg::gf_double(rnd_out);
      k2_q <= cmac_pkg::gf_double(cmac_pkg::gf_double(rnd_out));
    end
  end

  assign stat_o = '{keys_ok: (state_q == ST_IDLE) || (state_q == ST_RUN && !sub_q),
                    idle:    (state_q == ST_IDLE) && !done_q,
                    done:    done_q};
  assign result_o       = s_q;
  assign k1_o           = k1_q;
  assign k2_o           = k2_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE) else $error("done outside idle");
  a_run_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> cnt_q != '0 && cnt_q <= cmac_pkg::LastRnd)
    else $error("round count out of range");
  a_load_kexp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && !key_load_i) |=> state_q == ST_KEXP && cnt_q == '0)
    else $error("expansion did not start");

endmodule

`default_nettype wire

// ===== rtl/core/cmac_aes128_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

// AES-128 CMAC over a byte stream.
// Key: two 64-bit APB registers, key_high at 0x0 and key_low at 0x8. After
// reset and after every key write the round keys are expanded into an
// 11-entry memory and the subkeys derived, while in_ready_o is low.
// Input: one request per cycle, while in_ready_o is high, carries
// data_byte_i, byte_valid_i and last_byte_i. A full block is encrypted by the
// iterative round unit (one round per cycle) while the next block fills;
// in_ready_o drops if that block is full before the unit is free. A request
// with last_byte_i set closes the message; in_ready_o then stays low until the
// final block has entered the round unit; the tag follows its encryption.
// Output: two requests per message, high tag half first, last_word_o on the
// second. A stalled receiver holds the tag in the output register; the next
// message keeps streaming, and only its final block waits for that register.
// Reset clears the chaining value and the byte count.

module cmac_aes128_mac (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         byte_valid_i,
  input  wire logic         last_byte_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [63:0]       mac_word_o,
  output logic              last_word_o
);

  logic [cmac_pkg::HalfW-1:0]  key_hi_q, key_lo_q;
  logic                        key_load_q;
  logic [cmac_pkg::BlkW-1:0]   buf_q;
  logic [cmac_pkg::FillW-1:0]  fill_q;
  logic [cmac_pkg::BlkW-1:0]   chain_q;
  logic                        fin_pend_q;
  logic                        job_fin_q;
  logic [cmac_pkg::BlkW-1:0]   tag_q;
  logic                        out_vld_q;
  logic                        out_half_q;

  cmac_pkg::cmac_job_t         job;
  cmac_pkg::cmac_stat_t        stat;
  logic [cmac_pkg::BlkW-1:0]   result, k1, k2;
  logic [cmac_pkg::BlkW-1:0]   fin_blk;
  logic                        apb_wr, in_acc, full, absorb, fin_start;

  assign apb_wr    = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = paddr[3] ? key_lo_q : key_hi_q;
  assign full      = (fill_q == 5'd16);

  assign in_ready_o = stat.keys_ok && !key_load_q && !fin_pend_q && !(full && !stat.idle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign absorb     = in_acc && byte_valid_i && full;
  assign fin_start  = fin_pend_q && stat.idle && stat.keys_ok && !key_load_q && !out_vld_q;

  // complete block takes K1, short block is padded and takes K2
  always_comb begin
    for (int j = 0; j < cmac_pkg::BlkBytes; j++) begin
      if (full || (5'(j) < fill_q)) begin
        fin_blk[127 - 8*j -: 8] = buf_q[127 - 8*j -: 8];
      end else if (5'(j) == fill_q) begin
        fin_blk[127 - 8*j -: 8] = cmac_pkg::PadByte;
      end else begin
        fin_blk[127 - 8*j -: 8] = 8'h00;
      end
    end
    fin_blk = fin_blk ^ (full ? k1 : k2);
  end

  assign job = '{start: absorb || fin_start,
                 data:  chain_q ^ (absorb ? buf_q : fin_blk)};

  cmac_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      ({key_hi_q, key_lo_q}),
    .key_load_i (key_load_q),
    .job_i      (job),
    .stat_o     (stat),
    .result_o   (result),
    .k1_o       (k1),
    .k2_o       (k2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q   <= '0;
      key_lo_q   <= '0;
      key_load_q <= 1'b0;
      fill_q     <= '0;
      chain_q    <= '0;
      fin_pend_q <= 1'b0;
      job_fin_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      out_half_q <= 1'b0;
    end else begin
      key_load_q <= apb_wr;
      if (apb_wr) begin
        if (paddr[3]) begin
          key_lo_q <= pwdata;
        end else begin
          key_hi_q <= pwdata;
        end
      end
      if (in_acc) begin
        if (byte_valid_i) begin
          fill_q <= full ? 5'd1 : fill_q + 5'd1;
        end
        if (last_byte_i) begin
          fin_pend_q <= 1'b1;
        end
      end
      if (job.start) begin
        chain_q   <= '0;
        job_fin_q <= fin_start;
      end
      if (fin_start) begin
        fin_pend_q <= 1'b0;
        fill_q     <= '0;
      end
      if (stat.done && !job_fin_q) begin
        chain_q <= result;
      end
      // a block result may land while the tag is being read out
      if (stat.done && job_fin_q) begin
        out_vld_q  <= 1'b1;
        out_half_q <= 1'b0;
      end else if (out_vld_q && out_ready_i) begin
        if (out_half_q) begin
          out_vld_q <= 1'b0;
        end else begin
          out_half_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && byte_valid_i) begin
      buf_q[127 - 8*(full ? 4'd0 : fill_q[3:0]) -: 8] <= data_byte_i;
    end
    if (stat.done && job_fin_q) begin
      tag_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign mac_word_o  = out_half_q ? tag_q[63:0] : tag_q[127:64];
  assign last_word_o = out_half_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 5'd16) else $error("byte count overflow");
  a_tag_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.done && job_fin_q) |-> !out_vld_q) else $error("tag overwrites pending tag");
  a_key_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apb_wr |=> !in_ready_o) else $error("request taken during key update");
  a_one_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(absorb && fin_start)) else $error("two jobs in one cycle");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       fin;
  } byte_req_t;

  typedef struct packed {
    logic [63:0] word;
    logic        lst;
  } tag_word_t;

  localparam int unsigned StallLimit = 20000;
  localparam logic [3:0] AddrKeyHigh = 4'h0;
  localparam logic [3:0] AddrKeyLow  = 4'h8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        byte_valid_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] mac_word_o;
  logic        last_word_o;

  cmac_aes128_mac dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------- CMAC predictor ----------------
  logic [127:0] key_q;
  logic [127:0] rkeys [11];
  logic [127:0] k1_q, k2_q;
  logic [127:0] chain_q;
  logic [7:0]   blk_q [16];
  int unsigned  fill_q;
  tag_word_t    tag_fifo [$];

  function automatic logic [7:0] sub_byte(input logic [7:0] x);
    return cmac_pkg::SboxTbl[8*(255 - x) +: 8];
  endfunction

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] encrypt(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, sum;
    logic [127:0] r;
    r = blk ^ rkeys[0];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int i = 0; i < 16; i++) s[i] = r[127 - 8*i -: 8];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i + 4*c] = sub_byte(s[i + 4*((c + i) % 4)]);
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        sum = a0 ^ a1 ^ a2 ^ a3;
        if (rnd < 10) begin
          r[127 - 32*c -: 32] = {a0 ^ sum ^ gmul2(a0 ^ a1), a1 ^ sum ^ gmul2(a1 ^ a2),
                                 a2 ^ sum ^ gmul2(a2 ^ a3), a3 ^ sum ^ gmul2(a3 ^ a0)};
        end else begin
          r[127 - 32*c -: 32] = {a0, a1, a2, a3};
        end
      end
      r = r ^ rkeys[rnd];
    end
    return r;
  endfunction

  function automatic logic [127:0] gf_mul2(input logic [127:0] x);
    return {x[126:0], 1'b0} ^ (x[127] ? 128'h87 : 128'h0);
  endfunction

  task automatic expand_key();
    logic [31:0] w [44];
    logic [31:0] tw;
    logic [7:0]  rc;
    logic [127:0] lval;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key_q[127 - 32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      tw = w[i-1];
      if (i % 4 == 0) begin
        tw = {sub_byte(tw[23:16]) ^ rc, sub_byte(tw[15:8]), sub_byte(tw[7:0]),
              sub_byte(tw[31:24])};
        rc = gmul2(rc);
      end
      w[i] = w[i-4] ^ tw;
    end
    for (int r = 0; r < 11; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    lval = encrypt('0);
    k1_q = gf_mul2(lval);
    k2_q = gf_mul2(k1_q);
  endtask

  task automatic predict_byte(input byte_req_t rq);
    logic [127:0] fin_blk;
    if (rq.vld) begin
      if (fill_q >= 16) begin
        for (int i = 0; i < 16; i++) chain_q[127 - 8*i -: 8] ^= blk_q[i];
        chain_q = encrypt(chain_q);
        fill_q = 0;
      end
      blk_q[fill_q] = rq.data;
      fill_q++;
    end
    if (rq.fin) begin
      for (int i = 0; i < 16; i++)
        fin_blk[127 - 8*i -: 8] = (i < fill_q) ? blk_q[i] :
                                  ((i == fill_q) ? cmac_pkg::PadByte : 8'h00);
      chain_q = encrypt(chain_q ^ fin_blk ^ ((fill_q >= 16) ? k1_q : k2_q));
      tag_fifo.push_back('{word: chain_q[127:64], lst: 1'b0});
      tag_fifo.push_back('{word: chain_q[63:0], lst: 1'b1});
      chain_q = '0;
      fill_q = 0;
    end
  endtask

  // ---------------- sender ----------------
  byte_req_t   req_q [$];
  logic        in_took = 1'b0;
  int unsigned burst_left = 0, gap_left = 0;
  int unsigned in_count = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (req_q.size() > 0) begin
        byte_req_t rq;
        rq = req_q.pop_front();
        data_byte_i  <= rq.data;
        byte_valid_i <= rq.vld;
        last_byte_i  <= rq.fin;
        in_valid_i   <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------
  int unsigned hold_left = 0;
  bit          long_hold_done = 0;
  int unsigned stall_mode = 0, mode_left = 0;

  always @(negedge clk_i) begin
    if (!long_hold_done && in_count > 150) begin
      long_hold_done = 1;
      hold_left = 400;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(10, 80);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ~out_ready_i;
      endcase
    end
  end

  // ---------------- monitor and checker ----------------
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          apb_busy = 0;

  always @(posedge clk_i) begin
    in_took = in_valid_i && in_ready_o;
    if (rst_ni && in_took) begin
      predict_byte('{data: data_byte_i, vld: byte_valid_i, fin: last_byte_i});
      in_count++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tag_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tag word %h last=%b", mac_word_o, last_word_o);
      end else begin
        tag_word_t ex;
        ex = tag_fifo.pop_front();
        if (ex.word !== mac_word_o || ex.lst !== last_word_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tag mismatch: exp %h/%b got %h/%b", ex.word, ex.lst,
                     mac_word_o, last_word_o);
        end
      end
    end
    if (in_took || (out_valid_o && out_ready_i) || apb_busy || !rst_ni) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic key_write(input logic [3:0] addr, input logic [63:0] val);
    apb_busy = 1;
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == AddrKeyHigh) key_q[127:64] = val;
    else key_q[63:0] = val;
    expand_key();
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    apb_busy = 0;
  endtask

  task automatic drain();
    while (req_q.size() > 0 || in_valid_i || tag_fifo.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic queue_message(input int unsigned len, input bit close_empty);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0)
        req_q.push_back('{data: 8'($urandom), vld: 1'b0, fin: 1'b0});
      req_q.push_back('{data: 8'($urandom), vld: 1'b1,
                        fin: (i == len - 1) && !close_empty});
    end
    if (close_empty || len == 0) req_q.push_back('{data: 8'($urandom), vld: 1'b0, fin: 1'b1});
  endtask

  initial begin
    int unsigned len;
    key_q = '0;
    expand_key();
    chain_q = '0;
    fill_q = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero key from reset
    req_q.push_back('{data: 8'h00, vld: 1'b0, fin: 1'b1});   // empty message
    req_q.push_back('{data: 8'hff, vld: 1'b0, fin: 1'b0});   // idle request
    req_q.push_back('{data: 8'h00, vld: 1'b1, fin: 1'b1});   // one byte
    for (int i = 0; i < 16; i++)
      req_q.push_back('{data: (i % 2) ? 8'hff : 8'h00, vld: 1'b1, fin: i == 15});
    drain();

    key_write(AddrKeyHigh, '1);
    key_write(AddrKeyLow, '1);
    for (int i = 0; i < 16; i++) req_q.push_back('{data: 8'hff, vld: 1'b1, fin: 1'b0});
    req_q.push_back('{data: 8'h5a, vld: 1'b0, fin: 1'b1}); // complete block closed late
    queue_message(15, 0);
    // 20 bytes, then a key change mid-message
    for (int i = 0; i < 20; i++) req_q.push_back('{data: 8'(i * 13), vld: 1'b1, fin: 1'b0});
    drain();
    key_write(AddrKeyHigh, 64'h2b7e151628aed2a6);
    key_write(AddrKeyLow, 64'habf7158809cf4f3c);
    queue_message(5, 1);
    queue_message(32, 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      key_write(AddrKeyHigh, (ph == 4) ? 64'h0 : {$urandom, $urandom});
      key_write(AddrKeyLow, (ph == 3) ? 64'hffff_ffff_ffff_ffff : {$urandom, $urandom});
      repeat (4) begin
        len = ($urandom_range(0, 3) == 0) ? 16 * $urandom_range(1, 3) : $urandom_range(0, 20);
        queue_message(len, $urandom_range(0, 4) == 0);
      end
      drain();   // sender waits for every tag before moving on
    end

    if (mismatches == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
